>>> rtl/mbb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the masked 3x3 box blur.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package mbb_pkg;

    localparam int MAX_SIZE_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    // Result queue depth; sets how many results may be committed but not taken.
    localparam int FIFO_DEPTH = 16;

    // Configuration port
    localparam int                 CFG_W            = 11;
    localparam logic [CFG_W-1:0]   IMAGE_SIZE_RESET = 11'd1024;
    localparam int                 PADDR_W          = 3;
    localparam int                 PDATA_W          = 32;
    // Register index, taken from paddr[2]
    localparam logic [0:0]         REG_IMAGE_SIZE   = 1'b0;

    // Stream port widths
    localparam int CH_PORT_W = 16;
    localparam int TDATA_W   = 3 * CH_PORT_W;
    localparam int TUSER_W   = 2;
    localparam int TUSER_KEEP  = 0;
    localparam int TUSER_DRAIN = 1;

    // Position of the window center, relative to the image border
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } t_ctl;

    // What the divider needs besides the sums
    typedef struct packed {
        logic [1:0] nr;     // rows inside the image, 1..3
        logic [1:0] nc;     // columns inside the image, 1..3
        logic       keep;
        logic       last;
    } t_div_ctl;

    // Odd part of the pixel count
    typedef enum logic [1:0] {
        ODD_1,
        ODD_3,
        ODD_9
    } t_odd;

    typedef struct packed {
        logic [1:0] shift;
        t_odd       odd;
    } t_div;

    // Split rows*cols into a power of two and an odd factor of 1, 3 or 9.
    function automatic t_div div_of(input logic [1:0] nr, input logic [1:0] nc);
        logic [1:0] n2;
        logic [1:0] n3;
        t_div       d;
        n2 = {1'b0, (nr == 2'd2)} + {1'b0, (nc == 2'd2)};
        n3 = {1'b0, (nr == 2'd3)} + {1'b0, (nc == 2'd3)};
        d.shift = n2;
        unique case (n3)
            2'd0:    d.odd = ODD_1;
            2'd1:    d.odd = ODD_3;
            default: d.odd = ODD_9;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/masked_box_blur_3x3.sv
`timescale 1ns / 1ps
// Top level of the masked 3x3 box blur: config register, raster counters,
// credit flow control; uses mbb_pkg, mbb_line_store, mbb_window, mbb_divide, mbb_out_fifo.
//
// Masked 3x3 box blur over a square RGB image of image_size x image_size
// pixels, fed one word per pixel in raster order. A pixel word whose keep
// flag (tuser[0]) is clear comes out as the truncated mean, per channel, of
// its 3x3 neighborhood clipped to the image; a word with keep set comes out
// unchanged. Results leave in raster order, image_size+1 words behind the
// input: after the image_size*image_size pixel words, send image_size+1
// drain words (tuser[1] set, tdata ignored) to flush the frame; the last
// result carries tlast and the next word starts a new frame. A word of the
// wrong kind (drain while pixels are expected, or the reverse) is taken and
// dropped. The block takes one word per clock while tready is high: the line
// stores live in one RAM with a registered read and write-back, with
// forwarding when the same column is touched on consecutive words (image_size
// of 1). Up to 16 results may be committed and not yet taken; beyond that
// tready drops until the output side takes words. image_size 0 acts as 1 and
// values above MAX_SIZE act as MAX_SIZE. Write image_size only while the
// block is idle; a write restarts the frame. No clearing pass follows reset.
module masked_box_blur_3x3 #(
    parameter int MAX_SIZE     = mbb_pkg::MAX_SIZE_DEF,
    parameter int CHANNEL_BITS = mbb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbb_pkg::PADDR_W-1:0]   paddr,
    input  logic [mbb_pkg::PDATA_W-1:0]   pwdata,
    output logic [mbb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // Pixel stream in
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // in_red [15:0], in_green [31:16], in_blue [47:32]
    input  logic [mbb_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    // keep_source [0], drain [1]
    input  logic [mbb_pkg::TUSER_W-1:0]   i_s_axis_tuser,
    // Pixel stream out
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // out_red [15:0], out_green [31:16], out_blue [47:32]
    output logic [mbb_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    // frame_end
    output logic                          o_m_axis_tlast
);

    localparam int CB   = CHANNEL_BITS;
    localparam int CW   = $clog2(MAX_SIZE);
    localparam int DW   = $clog2(MAX_SIZE + 1);
    localparam int RW   = $clog2(MAX_SIZE + 2);
    localparam int EW   = (DW > mbb_pkg::CFG_W) ? DW : mbb_pkg::CFG_W;
    localparam int PXW  = 3 * CB + 1;
    localparam int FW   = 3 * CB + 1;
    localparam int FIFO_DEPTH = mbb_pkg::FIFO_DEPTH;
    localparam int CRW  = $clog2(FIFO_DEPTH + 1);
    localparam int CHW  = mbb_pkg::CH_PORT_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [mbb_pkg::CFG_W-1:0] r_image_size;
    logic                      w_cfg_wr;
    logic [EW-1:0]             w_cfg_ext;
    logic [DW-1:0]             w_dim;
    logic [CW-1:0]             w_last;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                   && (paddr[2] == mbb_pkg::REG_IMAGE_SIZE);
    assign prdata   = (paddr[2] == mbb_pkg::REG_IMAGE_SIZE)
                    ? mbb_pkg::PDATA_W'(r_image_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= mbb_pkg::IMAGE_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_image_size <= pwdata[mbb_pkg::CFG_W-1:0];
        end
    end

    // Clamp the register into 1..MAX_SIZE
    assign w_cfg_ext = EW'(r_image_size);
    always_comb begin
        if (r_image_size == '0) begin
            w_dim = DW'(1);
        end else if (w_cfg_ext > EW'(MAX_SIZE)) begin
            w_dim = DW'(MAX_SIZE);
        end else begin
            w_dim = DW'(w_cfg_ext);
        end
    end
    assign w_last = CW'(w_dim - DW'(1));

    // ------------------------------------------------------------------
    // Input side: raster counters and word classification
    // ------------------------------------------------------------------
    logic [CW-1:0]   r_in_col;    // column of the next input word
    logic [RW-1:0]   r_in_row;    // row of the next input word, drains past dim
    logic [CW-1:0]   r_out_col;   // window center of the next result
    logic [CW-1:0]   r_out_row;
    logic [CRW-1:0]  r_credit;    // results committed and not yet taken

    logic            w_drain;
    logic            w_pixel_phase;
    logic            w_acc;
    logic            w_take;
    logic            w_emit;
    logic            w_pop;
    mbb_pkg::t_ctl   w_ctl;
    logic [PXW-1:0]  w_px;

    assign w_drain       = i_s_axis_tuser[mbb_pkg::TUSER_DRAIN];
    assign w_pixel_phase = (r_in_row < RW'(w_dim));
    assign o_s_axis_tready = (r_credit < CRW'(FIFO_DEPTH));
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    // Drop a word of the wrong kind
    assign w_take = w_acc && (w_drain != w_pixel_phase);
    // A result comes out once a row and one pixel are in
    assign w_emit = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign w_pop  = o_m_axis_tvalid && i_m_axis_tready;

    assign w_ctl.top   = (r_out_row == '0);
    assign w_ctl.bot   = (r_out_row == w_last);
    assign w_ctl.left  = (r_out_col == '0);
    assign w_ctl.right = (r_out_col == w_last);
    assign w_ctl.last  = w_ctl.bot && w_ctl.right;

    // Drain words carry zero color and a clear keep flag
    assign w_px = w_drain ? '0
                : {i_s_axis_tuser[mbb_pkg::TUSER_KEEP],
                   i_s_axis_tdata[2*CHW +: CB],
                   i_s_axis_tdata[CHW +: CB],
                   i_s_axis_tdata[0 +: CB]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_take) begin
            if (w_emit && w_ctl.last) begin
                // Frame done: restart all counts
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (r_in_col == w_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (w_emit) begin
                    if (w_ctl.right) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + CW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    // Credit: a result slot is held from acceptance until the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRW'(w_take && w_emit) - CRW'(w_pop);
        end
    end

    // ------------------------------------------------------------------
    // Line store read / rotate / write back
    // ------------------------------------------------------------------
    logic            r_s1_emit;
    mbb_pkg::t_ctl   r_s1_ctl;
    logic            w_ls_valid;
    logic [PXW-1:0]  w_ls_older;
    logic [PXW-1:0]  w_ls_prior;
    logic [PXW-1:0]  w_ls_px;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_emit <= w_emit;
            r_s1_ctl  <= w_ctl;
        end
    end

    mbb_line_store #(
        .DEPTH (MAX_SIZE),
        .PW    (PXW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_take),
        .i_addr  (r_in_col),
        .i_px    (w_px),
        .o_valid (w_ls_valid),
        .o_older (w_ls_older),
        .o_prior (w_ls_prior),
        .o_px    (w_ls_px)
    );

    // ------------------------------------------------------------------
    // Window, sums, divide
    // ------------------------------------------------------------------
    logic                  w_win_valid;
    logic [2:0][CB+3:0]    w_total;
    logic [2:0][CB-1:0]    w_center;
    mbb_pkg::t_div_ctl     w_dctl;
    logic                  w_res_valid;
    logic [FW-1:0]         w_res_data;

    mbb_window #(
        .CB (CB)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_cfg_wr),
        .i_valid  (w_ls_valid),
        .i_emit   (r_s1_emit),
        .i_ctl    (r_s1_ctl),
        .i_older  (w_ls_older),
        .i_prior  (w_ls_prior),
        .i_px     (w_ls_px),
        .o_valid  (w_win_valid),
        .o_total  (w_total),
        .o_center (w_center),
        .o_dctl   (w_dctl)
    );

    mbb_divide #(
        .CB (CB)
    ) u_divide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_win_valid),
        .i_total  (w_total),
        .i_center (w_center),
        .i_dctl   (w_dctl),
        .o_valid  (w_res_valid),
        .o_data   (w_res_data)
    );

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [FW-1:0] w_fifo_data;

    mbb_out_fifo #(
        .WIDTH (FW),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res_data),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_fifo_data)
    );

    assign o_m_axis_tdata = {CHW'(w_fifo_data[2*CB +: CB]),
                             CHW'(w_fifo_data[CB +: CB]),
                             CHW'(w_fifo_data[0 +: CB])};
    assign o_m_axis_tlast = w_fifo_data[3*CB];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(FIFO_DEPTH))
        else $error("more results committed than the queue holds");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_emit && w_ctl.last && !w_cfg_wr)
        |=> (r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0))
        else $error("counters not restarted after the last result");

    a_center_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_row <= w_last) && (r_out_col <= w_last))
        else $error("window center outside the image");

endmodule

>>> rtl/mbb_line_store.sv
`timescale 1ns / 1ps
// Two line stores folded into one wide synchronous RAM, one entry per column.
// Read, rotate (older <- prior, prior <- new) and write back; uses mbb_pkg.
module mbb_line_store #(
    parameter int DEPTH = mbb_pkg::MAX_SIZE_DEF,
    parameter int PW    = 3 * mbb_pkg::CHANNEL_BITS_DEF + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [PW-1:0]            i_px,
    output logic                     o_valid,
    output logic [PW-1:0]            o_older,
    output logic [PW-1:0]            o_prior,
    output logic [PW-1:0]            o_px
);

    localparam int AW = $clog2(DEPTH);

    // Entry layout: older row in the upper half, prior row in the lower half
    logic [2*PW-1:0] r_mem [DEPTH];

    logic [2*PW-1:0] r_rd;
    logic [2*PW-1:0] r_fwd_data;
    logic            r_fwd;
    logic            r_valid;
    logic [AW-1:0]   r_addr;
    logic [PW-1:0]   r_px;
    logic [2*PW-1:0] w_rd_eff;
    logic [2*PW-1:0] w_wr_data;

    // Same column back to back: the RAM returned the entry before this write
    assign w_rd_eff  = r_fwd ? r_fwd_data : r_rd;
    assign w_wr_data = {w_rd_eff[PW-1:0], r_px};

    assign o_valid = r_valid;
    assign o_older = w_rd_eff[2*PW-1:PW];
    assign o_prior = w_rd_eff[PW-1:0];
    assign o_px    = r_px;

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_mem[r_addr] <= w_wr_data;
        end
        if (i_req) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_addr     <= i_addr;
            r_px       <= i_px;
            r_fwd_data <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_valid <= i_req;
            r_fwd   <= i_req && r_valid && (r_addr == i_addr);
        end
    end

    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_valid)
        else $error("forwarded entry without a live read");

endmodule

>>> rtl/mbb_window.sv
`timescale 1ns / 1ps
// 3x3 window registers plus two adder stages (column sums, then totals).
// Rows and columns outside the image are masked; uses mbb_pkg types.
module mbb_window #(
    parameter int CB = mbb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_valid,
    input  logic                        i_emit,
    input  mbb_pkg::t_ctl               i_ctl,
    input  logic [3*CB:0]               i_older,
    input  logic [3*CB:0]               i_prior,
    input  logic [3*CB:0]               i_px,
    output logic                        o_valid,
    output logic [2:0][CB+3:0]          o_total,
    output logic [2:0][CB-1:0]          o_center,
    output mbb_pkg::t_div_ctl           o_dctl
);

    localparam int CSW = CB + 2;
    localparam int TW  = CB + 4;

    // [column: 0 oldest][row: 0 top]
    logic [3*CB-1:0] r_win [3][3];
    logic            r_keep_mid;
    logic            r_keep_new;

    logic            r_s2_valid;
    mbb_pkg::t_ctl   r_s2_ctl;

    logic                       r_s3_valid;
    logic [2:0][2:0][CSW-1:0]   r_col;
    logic                       r_s3_left;
    logic                       r_s3_right;
    mbb_pkg::t_div_ctl          r_s3_dctl;
    logic [2:0][CB-1:0]         r_s3_center;

    logic                       r_s4_valid;
    logic [2:0][TW-1:0]         r_total;
    mbb_pkg::t_div_ctl          r_s4_dctl;
    logic [2:0][CB-1:0]         r_s4_center;

    logic [2:0][2:0][CSW-1:0]   w_col;
    logic [2:0][TW-1:0]         w_total;
    mbb_pkg::t_div_ctl          w_dctl;

    // Shift the window one column on every valid word from the line store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int c = 0; c < 3; c++) begin
                for (int d = 0; d < 3; d++) begin
                    r_win[c][d] <= '0;
                end
            end
            r_keep_mid <= 1'b0;
            r_keep_new <= 1'b0;
        end else if (i_valid) begin
            for (int c = 0; c < 2; c++) begin
                for (int d = 0; d < 3; d++) begin
                    r_win[c][d] <= r_win[c+1][d];
                end
            end
            r_win[2][0] <= i_older[3*CB-1:0];
            r_win[2][1] <= i_prior[3*CB-1:0];
            r_win[2][2] <= i_px[3*CB-1:0];
            r_keep_mid  <= r_keep_new;
            r_keep_new  <= i_prior[3*CB];
        end
    end

    // Column sums with the top and bottom rows masked at the border
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                w_col[c][k] = (r_s2_ctl.top ? CSW'(0) : CSW'(r_win[c][0][k*CB +: CB]))
                            + CSW'(r_win[c][1][k*CB +: CB])
                            + (r_s2_ctl.bot ? CSW'(0) : CSW'(r_win[c][2][k*CB +: CB]));
            end
        end
    end

    assign w_dctl.nr   = 2'd3 - 2'(r_s2_ctl.top) - 2'(r_s2_ctl.bot);
    assign w_dctl.nc   = 2'd3 - 2'(r_s2_ctl.left) - 2'(r_s2_ctl.right);
    assign w_dctl.keep = r_keep_mid;
    assign w_dctl.last = r_s2_ctl.last;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_total[k] = (r_s3_left ? TW'(0) : TW'(r_col[0][k]))
                       + TW'(r_col[1][k])
                       + (r_s3_right ? TW'(0) : TW'(r_col[2][k]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctl    <= i_ctl;
        r_col       <= w_col;
        r_s3_left   <= r_s2_ctl.left;
        r_s3_right  <= r_s2_ctl.right;
        r_s3_dctl   <= w_dctl;
        r_s3_center <= r_win[1][1];
        r_total     <= w_total;
        r_s4_dctl   <= r_s3_dctl;
        r_s4_center <= r_s3_center;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid && i_emit;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    assign o_valid  = r_s4_valid;
    assign o_total  = r_total;
    assign o_center = r_s4_center;
    assign o_dctl   = r_s4_dctl;

endmodule

>>> rtl/mbb_divide.sv
`timescale 1ns / 1ps
// Mean of 1, 2, 3, 4, 6 or 9 pixels: shift, then multiply by a reciprocal of
// 3 or 9 with one correction step. Uses mbb_pkg::div_of and mbb_pkg types.
module mbb_divide #(
    parameter int CB = mbb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [2:0][CB+3:0]   i_total,
    input  logic [2:0][CB-1:0]   i_center,
    input  mbb_pkg::t_div_ctl    i_dctl,
    output logic                 o_valid,
    output logic [3*CB:0]        o_data
);

    localparam int TW  = CB + 4;
    localparam int QW  = TW + 4;
    localparam int S   = CB + 8;
    localparam int MW  = S - 1;
    localparam int PRW = TW + MW;
    localparam longint unsigned ONE_S = 64'd1 << S;
    localparam logic [MW-1:0] RECIP_3 = MW'(ONE_S / 3);
    localparam logic [MW-1:0] RECIP_9 = MW'(ONE_S / 9);

    mbb_pkg::t_div          w_div;
    logic [MW-1:0]          w_recip;
    logic [2:0][TW-1:0]     w_x;
    logic [2:0][PRW-1:0]    w_prod;

    logic                   r_valid;
    logic [2:0][PRW-1:0]    r_prod;
    logic [2:0][TW-1:0]     r_x;
    mbb_pkg::t_odd          r_odd;
    logic [2:0][CB-1:0]     r_center;
    logic                   r_keep;
    logic                   r_last;

    logic [2:0][TW-1:0]     w_q;
    logic [2:0][QW-1:0]     w_qd;
    logic [2:0][QW-1:0]     w_dv;
    logic [2:0][QW-1:0]     w_rem;
    logic [2:0][TW-1:0]     w_mean;
    logic [2:0][CB-1:0]     w_chan;

    assign w_div   = mbb_pkg::div_of(i_dctl.nr, i_dctl.nc);
    assign w_recip = (w_div.odd == mbb_pkg::ODD_9) ? RECIP_9 : RECIP_3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_x[k]    = i_total[k] >> w_div.shift;
            w_prod[k] = PRW'(w_x[k]) * PRW'(w_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_x      <= w_x;
        r_odd    <= w_div.odd;
        r_center <= i_center;
        r_keep   <= i_dctl.keep;
        r_last   <= i_dctl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Estimate is exact or one low; bump it when the remainder reaches the divisor
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_q[k] = TW'(r_prod[k] >> S);
            unique case (r_odd)
                mbb_pkg::ODD_3: begin
                    w_qd[k] = (QW'(w_q[k]) << 1) + QW'(w_q[k]);
                    w_dv[k] = QW'(3);
                end
                mbb_pkg::ODD_9: begin
                    w_qd[k] = (QW'(w_q[k]) << 3) + QW'(w_q[k]);
                    w_dv[k] = QW'(9);
                end
                default: begin
                    w_qd[k] = QW'(r_x[k]);
                    w_dv[k] = QW'(1);
                end
            endcase
            w_rem[k]  = QW'(r_x[k]) - w_qd[k];
            w_mean[k] = (r_odd == mbb_pkg::ODD_1) ? r_x[k]
                      : w_q[k] + TW'(w_rem[k] >= w_dv[k]);
            w_chan[k] = r_keep ? r_center[k] : CB'(w_mean[k]);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_last, w_chan};

endmodule

>>> rtl/mbb_out_fifo.sv
`timescale 1ns / 1ps
// Result queue between the filter pipeline and the output stream.
// Flop-based, single read pointer; uses mbb_pkg for the default depth.
module mbb_out_fifo #(
    parameter int WIDTH = 3 * mbb_pkg::CHANNEL_BITS_DEF + 1,
    parameter int DEPTH = mbb_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + NW'(i_push) - NW'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == NW'(DEPTH))))
        else $error("result queue overflow");

endmodule
